// ----- src/lds_word_access_unit_defines.svh -----
// Assertion helpers for the word access unit.
`ifndef LDS_WORD_ACCESS_UNIT_DEFINES_SVH
`define LDS_WORD_ACCESS_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define LDS_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lds_word_access_unit: check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define LDS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lds_word_access_unit: check failed");

`endif

// ----- src/lds_wau_pkg.sv -----
package lds_wau_pkg;

  localparam int unsigned SHARE_WORDS = 16384;  // power of two
  localparam int unsigned WORD_AW     = $clog2(SHARE_WORDS);

  typedef logic [3:0] action_t;

  localparam action_t ACT_RD32  = 4'd0;
  localparam action_t ACT_RD64  = 4'd1;
  localparam action_t ACT_RD2   = 4'd2;
  localparam action_t ACT_WR32  = 4'd3;
  localparam action_t ACT_WR64  = 4'd4;
  localparam action_t ACT_ADD   = 4'd5;
  localparam action_t ACT_ADD_R = 4'd6;
  localparam action_t ACT_MIN   = 4'd7;
  localparam action_t ACT_MIN_R = 4'd8;
  localparam action_t ACT_MAX   = 4'd9;
  localparam action_t ACT_MAX_R = 4'd10;

  // controller -> datapath
  typedef struct packed {
    logic latch;      // capture input item
    logic rd_en;      // issue memory reads
    logic wr_lo;      // write data_low at word
    logic wr_hi;      // write data_high at word + 1
    logic wr_atomic;  // write atomic result at word
    logic out_load;   // load output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic valid_op;
    logic is_write;
    logic is_write64;
    logic is_atomic;
    logic has_result;
  } stat_t;

endpackage

// ----- src/lds_word_access_unit.sv -----
// Shared word memory that runs one thread access per item: 32/64-bit and dual reads,
// 32/64-bit writes and unsigned atomic add/min/max with optional return of the old word.
// Items are handled one at a time on a single-write, dual-read RAM with registered read
// data: a 32-bit write steps through accept and write, a 64-bit write through accept,
// low and high write, a read or an atomic through accept, RAM access, and result or
// write-back; an unused action code returns to idle with no result. A result sits in an
// output register, so the next item is accepted while it waits; only a second result
// finding that register still full stalls the unit. Word index is the byte address bits
// above bit 1, wrapped to the memory depth; unwritten words read back as garbage.
`include "lds_word_access_unit_defines.svh"

module lds_word_access_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  action_i,
  input  logic [31:0] base_addr_i,
  input  logic [7:0]  offset_a_i,
  input  logic [7:0]  offset_b_i,
  input  logic        stride_wide_i,
  input  logic [31:0] data_low_i,
  input  logic [31:0] data_high_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] read_low_o,
  output logic [31:0] read_high_o
);
  import lds_wau_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  lds_wau_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lds_wau_datapath u_datapath (
    .clk_i        (clk_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .action_i     (action_i),
    .base_addr_i  (base_addr_i),
    .offset_a_i   (offset_a_i),
    .offset_b_i   (offset_b_i),
    .stride_wide_i(stride_wide_i),
    .data_low_i   (data_low_i),
    .data_high_i  (data_high_i),
    .read_low_o   (read_low_o),
    .read_high_o  (read_high_o)
  );

  // one item in flight: busy right after an accept
  `LDS_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  // single write port, and no read in a write cycle
  `LDS_ASSERT_NOW(a_one_access, 1'b1,
                  $onehot0({cmd.rd_en, cmd.wr_lo, cmd.wr_hi, cmd.wr_atomic}))
  // results come only from returning actions, and never overwrite a waiting one
  `LDS_ASSERT_NOW(a_load_ok, cmd.out_load,
                  stat.has_result && (!out_valid_o || out_ready_i))

endmodule

// ----- src/lds_wau_ram.sv -----
module lds_wau_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr0_i,
  input  logic [AW-1:0]    raddr1_i,
  output logic [WIDTH-1:0] rdata0_o,
  output logic [WIDTH-1:0] rdata1_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata0_q;
  logic [WIDTH-1:0] rdata1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata0_q <= mem[raddr0_i];
      rdata1_q <= mem[raddr1_i];
    end
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

// ----- src/lds_wau_datapath.sv -----
module lds_wau_datapath (
  input  logic                 clk_i,
  input  lds_wau_pkg::cmd_t    cmd_i,
  output lds_wau_pkg::stat_t   stat_o,
  input  lds_wau_pkg::action_t action_i,
  input  logic [31:0]          base_addr_i,
  input  logic [7:0]           offset_a_i,
  input  logic [7:0]           offset_b_i,
  input  logic                 stride_wide_i,
  input  logic [31:0]          data_low_i,
  input  logic [31:0]          data_high_i,
  output logic [31:0]          read_low_o,
  output logic [31:0]          read_high_o
);
  import lds_wau_pkg::*;

  action_t     action_q;
  logic [31:0] base_q;
  logic [7:0]  off_a_q;
  logic [7:0]  off_b_q;
  logic        wide_q;
  logic [31:0] dlo_q;
  logic [31:0] dhi_q;
  logic [31:0] read_low_q;
  logic [31:0] read_high_q;

  logic [31:0]        single_addr;
  logic [31:0]        dual_addr0;
  logic [31:0]        dual_addr1;
  logic [31:0]        scaled_a;
  logic [31:0]        scaled_b;
  logic [WORD_AW-1:0] word_idx;
  logic [WORD_AW-1:0] word_next;
  logic [WORD_AW-1:0] raddr0;
  logic [WORD_AW-1:0] raddr1;
  logic               is_dual;
  logic               wide_read;
  logic [31:0]        old_word;
  logic [31:0]        second_word;
  logic [31:0]        atomic_val;
  logic               we;
  logic [WORD_AW-1:0] waddr;
  logic [31:0]        wdata;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      action_q <= action_i;
      base_q   <= base_addr_i;
      off_a_q  <= offset_a_i;
      off_b_q  <= offset_b_i;
      wide_q   <= stride_wide_i;
      dlo_q    <= data_low_i;
      dhi_q    <= data_high_i;
    end
    if (cmd_i.out_load) begin
      read_low_q  <= old_word;
      read_high_q <= wide_read ? second_word : 32'd0;
    end
  end

  // address generation; sums wrap at 32 bits
  assign single_addr = base_q + {16'd0, off_b_q, off_a_q};
  assign scaled_a    = wide_q ? {16'd0, off_a_q, 8'd0} : {22'd0, off_a_q, 2'd0};
  assign scaled_b    = wide_q ? {16'd0, off_b_q, 8'd0} : {22'd0, off_b_q, 2'd0};
  assign dual_addr0  = base_q + scaled_a;
  assign dual_addr1  = base_q + scaled_b;
  assign word_idx    = single_addr[WORD_AW+1:2];
  assign word_next   = word_idx + WORD_AW'(1);

  assign is_dual   = (action_q == ACT_RD2);
  assign wide_read = (action_q == ACT_RD64) || is_dual;
  assign raddr0    = is_dual ? dual_addr0[WORD_AW+1:2] : word_idx;
  assign raddr1    = is_dual ? dual_addr1[WORD_AW+1:2] : word_next;

  always_comb begin
    stat_o = '0;
    case (action_q)
      ACT_RD32, ACT_RD64, ACT_RD2: begin
        stat_o.valid_op   = 1'b1;
        stat_o.has_result = 1'b1;
      end
      ACT_WR32: begin
        stat_o.valid_op = 1'b1;
        stat_o.is_write = 1'b1;
      end
      ACT_WR64: begin
        stat_o.valid_op   = 1'b1;
        stat_o.is_write   = 1'b1;
        stat_o.is_write64 = 1'b1;
      end
      ACT_ADD, ACT_MIN, ACT_MAX: begin
        stat_o.valid_op  = 1'b1;
        stat_o.is_atomic = 1'b1;
      end
      ACT_ADD_R, ACT_MIN_R, ACT_MAX_R: begin
        stat_o.valid_op   = 1'b1;
        stat_o.is_atomic  = 1'b1;
        stat_o.has_result = 1'b1;
      end
      default: stat_o = '0;
    endcase
  end

  // unsigned read-modify-write on the old word
  always_comb begin
    case (action_q)
      ACT_ADD, ACT_ADD_R: atomic_val = old_word + dlo_q;
      ACT_MIN, ACT_MIN_R: atomic_val = (dlo_q < old_word) ? dlo_q : old_word;
      default:            atomic_val = (dlo_q > old_word) ? dlo_q : old_word;
    endcase
  end

  assign we    = cmd_i.wr_lo || cmd_i.wr_hi || cmd_i.wr_atomic;
  assign waddr = cmd_i.wr_hi ? word_next : word_idx;
  assign wdata = cmd_i.wr_hi ? dhi_q : (cmd_i.wr_atomic ? atomic_val : dlo_q);

  lds_wau_ram #(
    .DEPTH(SHARE_WORDS),
    .WIDTH(32)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr0_i(raddr0),
    .raddr1_i(raddr1),
    .rdata0_o(old_word),
    .rdata1_o(second_word)
  );

  assign read_low_o  = read_low_q;
  assign read_high_o = read_high_q;

endmodule

// ----- src/lds_wau_ctrl.sv -----
module lds_wau_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  lds_wau_pkg::stat_t stat_i,
  output lds_wau_pkg::cmd_t  cmd_o
);
  import lds_wau_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_EXEC,
    S_WR_HI,
    S_HOLD
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  // output register frees up in the same cycle it is taken
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.latch = in_valid_i;
        if (in_valid_i) begin
          state_d = S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (!stat_i.valid_op) begin
          state_d = S_IDLE;
        end else if (stat_i.is_write) begin
          cmd_o.wr_lo = 1'b1;
          state_d     = stat_i.is_write64 ? S_WR_HI : S_IDLE;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.wr_atomic = stat_i.is_atomic;
        if (!stat_i.has_result) begin
          state_d = S_IDLE;
        end else if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end else begin
          state_d = S_HOLD;
        end
      end
      S_WR_HI: begin
        cmd_o.wr_hi = 1'b1;
        state_d     = S_IDLE;
      end
      S_HOLD: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
